// ----- hw/rtl/clr_pkg.sv -----
// Shared constants, types and helpers for the clipped line rasterizer.
// Used by the channel interfaces, the divider and the top level.
package clr_pkg;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int CW        = 13;              // coordinate width
    localparam int DIM_W     = 13;              // screen size register width
    localparam int ADDR_W    = 24;
    localparam int COLOR_W   = 32;
    localparam int NUM_W     = 2 * CW + 2;      // running numerator y1*dx + dy*k
    localparam int MB_W      = imax(CW + 2, DIM_W + 1);
    localparam int P_W       = CW + MB_W;       // shared multiplier product
    localparam int CMP_W     = imax(CW, DIM_W);
    localparam int ASUM_W    = imax(P_W, ADDR_W) + 1;
    localparam int DIV_CNT_W = $clog2(CW);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = DIM_W;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [1:0] MODE_H = 2'd0;
    localparam logic [1:0] MODE_V = 2'd1;
    localparam logic [1:0] MODE_G = 2'd2;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] dividend;
        logic [CW:0]             divisor;
    } div_req_t;

    typedef struct packed {
        logic   done;
        coord_t quotient;
    } div_res_t;

    // 0 <= px < w and 0 <= py < h
    function automatic logic on_screen(input coord_t px, input coord_t py,
                                       input logic [DIM_W-1:0] w,
                                       input logic [DIM_W-1:0] h);
        logic [CMP_W-1:0] px_u;
        logic [CMP_W-1:0] py_u;
        px_u = CMP_W'($unsigned(px));
        py_u = CMP_W'($unsigned(py));
        return !px[CW-1] && !py[CW-1] && (px_u < CMP_W'(w)) && (py_u < CMP_W'(h));
    endfunction

endpackage

// ----- hw/rtl/clr_if.sv -----
// Valid/ready channel interfaces: command beats in, pixel write beats out.
// Depends on clr_pkg.
interface clr_cmd_if;
    import clr_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    coord_t              start_x;
    coord_t              start_y;
    coord_t              end_x;
    coord_t              end_y;
    logic [COLOR_W-1:0]  pixel_color;

    modport source (output valid, operation, start_x, start_y, end_x, end_y, pixel_color,
                    input ready);
    modport sink   (input valid, operation, start_x, start_y, end_x, end_y, pixel_color,
                    output ready);
endinterface

interface clr_pix_if;
    import clr_pkg::*;

    logic                valid;
    logic                ready;
    coord_t              pixel_x;
    coord_t              pixel_y;
    logic                inside_res;
    logic [ADDR_W-1:0]   pixel_address;
    logic [COLOR_W-1:0]  out_color;
    logic                last_pixel;

    modport source (output valid, pixel_x, pixel_y, inside_res, pixel_address, out_color,
                    last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, inside_res, pixel_address, out_color,
                    last_pixel, output ready);
endinterface

// ----- hw/rtl/clr_divider.sv -----
// Restoring signed-by-positive divider, one quotient bit per cycle,
// truncating toward zero. Depends on clr_pkg.
module clr_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  clr_pkg::div_req_t req,
    output clr_pkg::div_res_t res
);
    import clr_pkg::*;

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CW:0]           rem_reg, rem_next;
    logic [CW-1:0]         quo_reg, quo_next;
    logic [CW:0]           dvsr_reg, dvsr_next;
    logic                  neg_reg, neg_next;

    logic [NUM_W-1:0]      mag;
    logic [CW+1:0]         trial;
    logic [CW+2:0]         diff;
    logic                  ge;
    logic                  last_bit;

    // |num| < dx * 2^CW, so the bits above CW already sit below the divisor
    assign mag      = req.dividend[NUM_W-1] ? $unsigned(-req.dividend)
                                            : $unsigned(req.dividend);
    assign trial    = {rem_reg, quo_reg[CW-1]};
    assign diff     = {1'b0, trial} - {2'b00, dvsr_reg};
    assign ge       = !diff[CW+2];
    assign last_bit = (cnt_reg == DIV_CNT_W'(CW - 1));

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            rem_next  = mag[2*CW:CW];
            quo_next  = mag[CW-1:0];
            dvsr_next = req.divisor;
            neg_next  = req.dividend[NUM_W-1];
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[CW:0] : trial[CW:0];
            quo_next = {quo_reg[CW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (last_bit)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
        neg_reg  <= neg_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ----- hw/rtl/clipped_line_rasterizer.sv -----
// Top level of the clipped line rasterizer: sequencer, shared multiplier,
// clipping and output register. Depends on clr_pkg, clr_if.sv, clr_divider.
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  cmd     | in  | operation, start_x, start_y, end_x, end_y, pixel_color
//  pix     | out | pixel_x, pixel_y, inside_res, pixel_address, out_color,
//          |     | last_pixel
//  cfg     | in  | cfg_we, cfg_index, cfg_data (0 width, 1 height)
//
// Start beat: horizontal/vertical lines stay in idle, general lines take one
// pass through the shared multiplier in S_SETUP. Step beat: S_ADDR for
// horizontal/vertical lines, S_DIV and S_ADDR for general lines, the divider
// retiring one quotient bit per cycle. cmd.ready is low until the sequencer
// is back in idle. A held pixel beat lets the next command in; its pixel
// waits in S_ADDR. Reset loads width 640, height 480 and drops any line.
module clipped_line_rasterizer
(
    input  logic                             clk,
    input  logic                             rst_n,
    clr_cmd_if.sink                          cmd,
    clr_pix_if.source                        pix,
    input  logic                             cfg_we,
    input  logic [clr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clr_pkg::CFG_W-1:0]        cfg_data
);
    import clr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_ADDR  = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic                    busy_reg, busy_next;
    logic [1:0]              mode_reg, mode_next;
    coord_t                  cursor_reg, cursor_next;
    coord_t                  cursor_end_reg, cursor_end_next;
    coord_t                  anchor_x_reg, anchor_x_next;
    coord_t                  anchor_y_reg, anchor_y_next;
    logic [CW:0]             delta_x_reg, delta_x_next;
    logic signed [CW:0]      delta_y_reg, delta_y_next;
    logic [COLOR_W-1:0]      color_reg, color_next;
    logic signed [NUM_W-1:0] num_reg, num_next;
    logic [DIM_W-1:0]        width_reg, width_next;
    logic [DIM_W-1:0]        height_reg, height_next;
    coord_t                  px_reg, px_next;
    coord_t                  py_reg, py_next;
    logic                    last_reg, last_next;

    logic                    out_valid_reg, out_valid_next;
    coord_t                  out_x_reg, out_x_next;
    coord_t                  out_y_reg, out_y_next;
    logic                    out_in_reg, out_in_next;
    logic [ADDR_W-1:0]       out_addr_reg, out_addr_next;
    logic [COLOR_W-1:0]      out_color_reg, out_color_next;
    logic                    out_last_reg, out_last_next;

    logic                    cmd_fire;
    logic                    is_h, is_v, swap;
    coord_t                  xa, ya, xb, yb;
    logic signed [CW-1:0]    mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [P_W-1:0]   mul_p;
    logic [ASUM_W-1:0]       addr_sum;
    logic                    on_scr;

    div_req_t                div_req;
    div_res_t                div_res;

    clr_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign is_h = (cmd.start_y == cmd.end_y);
    assign is_v = (cmd.start_x == cmd.end_x);
    assign swap = (cmd.start_x > cmd.end_x);
    assign xa   = swap ? cmd.end_x   : cmd.start_x;
    assign ya   = swap ? cmd.end_y   : cmd.start_y;
    assign xb   = swap ? cmd.start_x : cmd.end_x;
    assign yb   = swap ? cmd.start_y : cmd.end_y;

    // one multiplier: y1*dx at line setup, y*width for the address
    assign mul_a = (state_reg == S_SETUP) ? anchor_y_reg : py_reg;
    assign mul_b = (state_reg == S_SETUP) ? $signed(MB_W'(delta_x_reg))
                                          : $signed(MB_W'(width_reg));
    assign mul_p = P_W'(mul_a) * P_W'(mul_b);

    assign on_scr   = on_screen(px_reg, py_reg, width_reg, height_reg);
    assign addr_sum = ASUM_W'($unsigned(mul_p)) + ASUM_W'($unsigned(px_reg));

    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        mode_next       = mode_reg;
        cursor_next     = cursor_reg;
        cursor_end_next = cursor_end_reg;
        anchor_x_next   = anchor_x_reg;
        anchor_y_next   = anchor_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        color_next      = color_reg;
        num_next        = num_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_in_next     = out_in_reg;
        out_addr_next   = out_addr_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;
        div_req.start    = 1'b0;
        div_req.dividend = num_reg;
        div_req.divisor  = delta_x_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_next  = cfg_data;
                REG_HEIGHT: height_next = cfg_data;
                default:    ;
            endcase
        end

        if (pix.valid && pix.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire && cmd.operation == OP_START)
                begin
                    busy_next  = 1'b1;
                    color_next = cmd.pixel_color;
                    if (is_h)
                    begin
                        mode_next       = MODE_H;
                        anchor_y_next   = cmd.start_y;
                        cursor_next     = swap ? cmd.end_x : cmd.start_x;
                        cursor_end_next = swap ? cmd.start_x : cmd.end_x;
                    end
                    else if (is_v)
                    begin
                        mode_next       = MODE_V;
                        anchor_x_next   = cmd.start_x;
                        cursor_next     = (cmd.start_y < cmd.end_y) ? cmd.start_y : cmd.end_y;
                        cursor_end_next = (cmd.start_y < cmd.end_y) ? cmd.end_y : cmd.start_y;
                    end
                    else
                    begin
                        mode_next       = MODE_G;
                        anchor_x_next   = xa;
                        anchor_y_next   = ya;
                        delta_x_next    = $unsigned((CW+1)'(xb) - (CW+1)'(xa));
                        delta_y_next    = (CW+1)'(yb) - (CW+1)'(ya);
                        cursor_next     = xa;
                        cursor_end_next = xb;
                        state_next      = S_SETUP;
                    end
                end
                else if (cmd_fire && busy_reg)
                begin
                    last_next = (cursor_reg >= cursor_end_reg);
                    if (cursor_reg >= cursor_end_reg)
                        busy_next = 1'b0;
                    else
                        cursor_next = cursor_reg + 1'b1;
                    case (mode_reg)
                        MODE_H:
                        begin
                            px_next    = cursor_reg;
                            py_next    = anchor_y_reg;
                            state_next = S_ADDR;
                        end
                        MODE_V:
                        begin
                            px_next    = anchor_x_reg;
                            py_next    = cursor_reg;
                            state_next = S_ADDR;
                        end
                        default:
                        begin
                            // divider latches the numerator for this x; advance it by dy
                            px_next       = cursor_reg;
                            div_req.start = 1'b1;
                            num_next      = num_reg + NUM_W'(delta_y_reg);
                            state_next    = S_DIV;
                        end
                    endcase
                end
            end
            S_SETUP:
            begin
                num_next   = mul_p[NUM_W-1:0];
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    py_next    = div_res.quotient;
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                if (!out_valid_reg || pix.ready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = px_reg;
                    out_y_next     = py_reg;
                    out_in_next    = on_scr;
                    out_addr_next  = on_scr ? addr_sum[ADDR_W-1:0] : '0;
                    out_color_next = color_reg;
                    out_last_next  = last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            mode_reg      <= MODE_H;
            out_valid_reg <= 1'b0;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg     <= cursor_next;
        cursor_end_reg <= cursor_end_next;
        anchor_x_reg   <= anchor_x_next;
        anchor_y_reg   <= anchor_y_next;
        delta_x_reg    <= delta_x_next;
        delta_y_reg    <= delta_y_next;
        color_reg      <= color_next;
        num_reg        <= num_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        last_reg       <= last_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_in_reg     <= out_in_next;
        out_addr_reg   <= out_addr_next;
        out_color_reg  <= out_color_next;
        out_last_reg   <= out_last_next;
    end

    assign pix.valid         = out_valid_reg;
    assign pix.pixel_x       = out_x_reg;
    assign pix.pixel_y       = out_y_reg;
    assign pix.inside_res    = out_in_reg;
    assign pix.pixel_address = out_addr_reg;
    assign pix.out_color     = out_color_reg;
    assign pix.last_pixel    = out_last_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_setup_general: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SETUP |-> mode_reg == MODE_G && busy_reg)
        else $error("slope setup without a general line");

    a_clip_addr: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && !pix.inside_res |-> pix.pixel_address == '0)
        else $error("address on a clipped pixel");

    a_step_holds_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && cmd.operation == OP_STEP && busy_reg |=> !cmd.ready)
        else $error("command taken while a pixel is in flight");

endmodule

// ----- tb/sv/tb_clipped_line_rasterizer.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for clipped_line_rasterizer: directed and random
// line commands, screen size sweeps and output stalls against a local pixel predictor.
// Depends on clr_pkg, clr_if.sv (clr_cmd_if, clr_pix_if) and the block's RTL.
module tb_clipped_line_rasterizer;
    import clr_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        coord_t              x;
        coord_t              y;
        logic                on_scr;
        logic [ADDR_W-1:0]   addr;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    clr_cmd_if cmd_ch();
    clr_pix_if pix_ch();

    clipped_line_rasterizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .pix       (pix_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the screen registers and the line sequencer
    logic [DIM_W-1:0]   scr_w;
    logic [DIM_W-1:0]   scr_h;
    logic               line_busy;
    logic [1:0]         line_mode;
    int                 cursor;
    int                 cursor_end;
    int                 anchor_x;
    int                 anchor_y;
    int                 delta_x;
    int                 delta_y;
    logic [COLOR_W-1:0] line_color;

    pixel_t pending_pixels[$];

    int  items_sent;
    int  pixels_checked;
    int  clipped_pixels;
    int  settings_used;
    int  mismatch_cnt;
    int  hold_request;
    int  idle_cycles = 0;
    bit  steady;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic void reset_predictor();
        scr_w      = WIDTH_RESET;
        scr_h      = HEIGHT_RESET;
        line_busy  = 1'b0;
        line_mode  = MODE_H;
        cursor     = 0;
        cursor_end = 0;
        anchor_x   = 0;
        anchor_y   = 0;
        delta_x    = 0;
        delta_y    = 0;
        line_color = '0;
    endfunction

    function automatic void setup_line(input coord_t sx, input coord_t sy,
                                       input coord_t ex, input coord_t ey,
                                       input logic [COLOR_W-1:0] color);
        int x1, y1, x2, y2;
        x1 = sx;
        y1 = sy;
        x2 = ex;
        y2 = ey;
        line_color = color;
        line_busy  = 1'b1;
        if (y1 == y2) begin
            line_mode  = MODE_H;
            anchor_y   = y1;
            cursor     = (x1 < x2) ? x1 : x2;
            cursor_end = (x1 < x2) ? x2 : x1;
        end
        else if (x1 == x2) begin
            line_mode  = MODE_V;
            anchor_x   = x1;
            cursor     = (y1 < y2) ? y1 : y2;
            cursor_end = (y1 < y2) ? y2 : y1;
        end
        else begin
            line_mode = MODE_G;
            // walk with x ascending
            if (x1 > x2) begin
                anchor_x = x2;
                anchor_y = y2;
                delta_x  = x1 - x2;
                delta_y  = y1 - y2;
            end
            else begin
                anchor_x = x1;
                anchor_y = y1;
                delta_x  = x2 - x1;
                delta_y  = y2 - y1;
            end
            cursor     = anchor_x;
            cursor_end = anchor_x + delta_x;
        end
    endfunction

    function automatic pixel_t next_pixel();
        pixel_t p;
        longint px, py, num;
        if (line_mode == MODE_H) begin
            px = cursor;
            py = anchor_y;
        end
        else if (line_mode == MODE_V) begin
            px = anchor_x;
            py = cursor;
        end
        else begin
            px = cursor;
            if (delta_x > 0) begin
                num = longint'(anchor_y) * delta_x + longint'(delta_y) * (cursor - anchor_x);
                py = num / delta_x;     // truncates toward zero
            end
            else begin
                py = anchor_y;
            end
        end
        p.x      = coord_t'(px);
        p.y      = coord_t'(py);
        p.on_scr = (px >= 0) && (py >= 0) && (px < longint'(scr_w)) && (py < longint'(scr_h));
        p.addr   = p.on_scr ? ADDR_W'(py * longint'(scr_w) + px) : '0;
        p.color  = line_color;
        p.last   = (cursor >= cursor_end);
        if (p.last)
            line_busy = 1'b0;
        else
            cursor = cursor + 1;
        return p;
    endfunction

    function automatic void track_command(input logic op, input coord_t sx, input coord_t sy,
                                          input coord_t ex, input coord_t ey,
                                          input logic [COLOR_W-1:0] color);
        pixel_t p;
        if (op == OP_START) begin
            setup_line(sx, sy, ex, ey, color);
        end
        else if (line_busy) begin
            p = next_pixel();
            if (!p.on_scr)
                clipped_pixels++;
            pending_pixels.push_back(p);
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_cmd(input logic op, input coord_t sx, input coord_t sy,
                            input coord_t ex, input coord_t ey,
                            input logic [COLOR_W-1:0] color);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.operation   <= op;
        cmd_ch.start_x     <= sx;
        cmd_ch.start_y     <= sy;
        cmd_ch.end_x       <= ex;
        cmd_ch.end_y       <= ey;
        cmd_ch.pixel_color <= color;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        track_command(op, sx, sy, ex, ey, color);
        items_sent++;
    endtask

    task automatic send_start(input int x1, input int y1, input int x2, input int y2,
                              input logic [COLOR_W-1:0] color);
        send_cmd(OP_START, coord_t'(x1), coord_t'(y1), coord_t'(x2), coord_t'(y2), color);
    endtask

    // coordinate fields are don't-care on a step; keep them toggling anyway
    task automatic send_step();
        send_cmd(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), $urandom);
    endtask

    task automatic finish_line();
        while (line_busy)
            send_step();
    endtask

    // finish any open line, drain the output side, then let the sequencer go quiet
    task automatic settle();
        finish_line();
        cmd_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_screen(input int w, input int h);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(posedge clk);
        scr_w      = DIM_W'(w);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(posedge clk);
        scr_h   = DIM_W'(h);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic int clamp_coord(input int v);
        if (v < -4096)
            return -4096;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    // around the visible area, with a margin on both sides
    function automatic int near_screen(input int span);
        return clamp_coord(int'($urandom_range(0, span + 40)) - 20);
    endfunction

    function automatic int spread(input int len);
        return int'($urandom_range(0, 2 * len)) - len;
    endfunction

    task automatic start_short_line();
        int x1, y1, x2, y2, len, kind;
        x1   = near_screen(int'(scr_w));
        y1   = near_screen(int'(scr_h));
        len  = ($urandom_range(0, 15) == 0) ? 200 : 24;
        kind = $urandom_range(0, 7);
        x2   = clamp_coord(x1 + spread(len));
        y2   = clamp_coord(y1 + spread(len));
        if (kind == 0)
            y2 = y1;
        else if (kind == 1)
            x2 = x1;
        else if (kind == 2) begin
            x2 = x1;
            y2 = y1;
        end
        send_start(x1, y1, x2, y2, $urandom);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_step();                                        // step with no line open
        send_start(0, 0, 0, 0, 32'hFFFF_FFFF);              // single point
        finish_line();
        send_start(5, 3, 2, 3, 32'h0000_0000);              // horizontal, reversed
        finish_line();
        send_start(7, 9, 7, 6, 32'hA5A5_A5A5);              // vertical, reversed
        finish_line();
        send_start(3, -7, -2, 5, 32'h5A5A_5A5A);            // swapped, negative numerators
        finish_line();
        send_start(-4096, 4095, 4095, -4096, 32'h8000_0001); // field extremes
        send_step();
        send_step();
        send_start(4095, -4096, -4096, 4095, 32'h7FFF_FFFE); // restart abandons the line
        send_step();
    endtask

    task automatic test_random_lines(input int n_items);
        int target, r;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(0, 19) == 0)
                steady = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 72) begin
                start_short_line();
                finish_line();
                if ($urandom_range(0, 9) == 0)
                    send_step();
            end
            else if (r < 84) begin
                start_short_line();
                repeat ($urandom_range(0, 4)) send_step();
            end
            else if (r < 92) begin
                send_cmd(OP_START, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), $urandom);
                repeat ($urandom_range(0, 4)) send_step();
            end
            else begin
                send_cmd($urandom_range(0, 1) ? OP_STEP : OP_START, coord_t'($urandom),
                         coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), $urandom);
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_screen_sweep();
        int sweep_w[7];
        int sweep_h[7];
        sweep_w = '{1, 4096, 0, 8191, 1, 4096, 0};
        sweep_h = '{1, 4096, 0, 8191, 4096, 1, 0};
        sweep_w[6] = $urandom_range(1, 4096);
        sweep_h[6] = $urandom_range(1, 4096);
        for (int i = 0; i < 7; i++) begin
            write_screen(sweep_w[i], sweep_h[i]);
            test_random_lines(110);
        end
        write_screen(640, 480);
    endtask

    // long output stall while lines keep coming, so the input backs up
    task automatic test_output_stall();
        steady       = 1'b1;
        hold_request = 400;
        send_start(10, 10, 70, 40, $urandom);
        finish_line();
        hold_request = 300;
        send_start(100, 20, 60, 20, $urandom);
        finish_line();
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- checker

    initial begin
        pixel_t exp_p;
        pixel_t got;
        int stall;
        pix_ch.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            stall = (hold_request > 0) ? hold_request : (steady ? 0 : $urandom_range(0, 3));
            hold_request = 0;
            if (stall > 0) begin
                pix_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pix_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!pix_ch.valid);
            got.x      = pix_ch.pixel_x;
            got.y      = pix_ch.pixel_y;
            got.on_scr = pix_ch.inside_res;
            got.addr   = pix_ch.pixel_address;
            got.color  = pix_ch.out_color;
            got.last   = pix_ch.last_pixel;
            if (pending_pixels.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected pixel beat x=%0d y=%0d in=%0b addr=%h col=%h last=%0b",
                             $time, got.x, got.y, got.on_scr, got.addr, got.color, got.last);
            end
            else begin
                exp_p = pending_pixels.pop_front();
                pixels_checked++;
                if (got !== exp_p) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"%0t: pixel mismatch exp x=%0d y=%0d in=%0b addr=%h col=%h last=%0b",
                                  " got x=%0d y=%0d in=%0b addr=%h col=%h last=%0b"}, $time,
                                 exp_p.x, exp_p.y, exp_p.on_scr, exp_p.addr, exp_p.color, exp_p.last,
                                 got.x, got.y, got.on_scr, got.addr, got.color, got.last);
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk) begin
        if (rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- main

    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.operation   = OP_START;
        cmd_ch.start_x     = '0;
        cmd_ch.start_y     = '0;
        cmd_ch.end_x       = '0;
        cmd_ch.end_y       = '0;
        cmd_ch.pixel_color = '0;
        items_sent         = 0;
        pixels_checked     = 0;
        clipped_pixels     = 0;
        settings_used      = 1;
        mismatch_cnt       = 0;
        hold_request       = 0;
        steady             = 1'b0;
        reset_predictor();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_lines(700);
        test_screen_sweep();
        test_output_stall();

        cmd_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
            mismatch_cnt++;

        $display("Ran %0d commands over %0d screen settings (including zero and full size).",
                 items_sent, settings_used);
        $display("Checked %0d pixel beats, %0d of them clipped; %0d mismatches.",
                 pixels_checked, clipped_pixels, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/clr_pkg.sv
hw/rtl/clr_if.sv
hw/rtl/clr_divider.sv
hw/rtl/clipped_line_rasterizer.sv
tb/sv/tb_clipped_line_rasterizer.sv
